/* hw/rtl/arenc_pkg.sv */
package arenc_pkg;

  localparam int COUNT_BITS  = 14;
  localparam int TOTAL_BITS  = COUNT_BITS + 1;
  localparam int REM_BITS    = TOTAL_BITS + 1;
  localparam int PEND_BITS   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int PC_BITS     = 3;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = TOTAL_BITS'(1) << COUNT_BITS;

  typedef logic [PC_BITS-1:0] pc_t;
  typedef logic [2:0] op_t;
  typedef logic [2:0] cond_t;

  // Datapath operations, one per control word.
  localparam op_t OP_IDLE   = 3'd0;
  localparam op_t OP_MUL_HI = 3'd1;
  localparam op_t OP_MUL_LO = 3'd2;
  localparam op_t OP_DIV    = 3'd3;
  localparam op_t OP_NARROW = 3'd4;
  localparam op_t OP_RENORM = 3'd5;
  localparam op_t OP_FLUSH  = 3'd6;
  localparam op_t OP_FIN    = 3'd7;

  // Jump conditions; a taken jump loads the target, otherwise the step counter advances.
  localparam cond_t COND_NONE     = 3'd0;
  localparam cond_t COND_ALWAYS   = 3'd1;
  localparam cond_t COND_FIN      = 3'd2;
  localparam cond_t COND_DIV_MORE = 3'd3;
  localparam cond_t COND_RENORM   = 3'd4;

  localparam pc_t PC_IDLE   = 3'd0;
  localparam pc_t PC_MUL_HI = 3'd1;
  localparam pc_t PC_MUL_LO = 3'd2;
  localparam pc_t PC_DIV    = 3'd3;
  localparam pc_t PC_NARROW = 3'd4;
  localparam pc_t PC_RENORM = 3'd5;
  localparam pc_t PC_FLUSH  = 3'd6;
  localparam pc_t PC_FIN    = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    case (pc)
      PC_IDLE:   w = '{op: OP_IDLE,   cond: COND_FIN,      target: PC_FIN};
      PC_MUL_HI: w = '{op: OP_MUL_HI, cond: COND_NONE,     target: PC_IDLE};
      PC_MUL_LO: w = '{op: OP_MUL_LO, cond: COND_NONE,     target: PC_IDLE};
      PC_DIV:    w = '{op: OP_DIV,    cond: COND_DIV_MORE, target: PC_DIV};
      PC_NARROW: w = '{op: OP_NARROW, cond: COND_NONE,     target: PC_IDLE};
      PC_RENORM: w = '{op: OP_RENORM, cond: COND_RENORM,   target: PC_RENORM};
      PC_FLUSH:  w = '{op: OP_FLUSH,  cond: COND_ALWAYS,   target: PC_IDLE};
      PC_FIN:    w = '{op: OP_FIN,    cond: COND_ALWAYS,   target: PC_FLUSH};
      default:   w = '{op: OP_IDLE,   cond: COND_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/arithmetic_encoder_16bit_unit.sv */
// Integer arithmetic encoder with a static model. Each symbol beat gives the cumulative
// counts below and through the symbol; total_count must be written while the block is idle.
// A symbol runs two multiply steps, CODE_BITS + 1 steps of the bit-serial divider that
// scales the range by the total count (both bounds in parallel), one narrowing step, the
// renormalization shift loop and a final flush; a finish beat runs the termination step
// and the flush. A step that hands over a result waits while that result cannot drain.
// Results pass through a one-entry hold stage and an output register, so the encoder only
// waits when both are full. An invalid symbol is taken and dropped while the encoder stays idle.
module arithmetic_encoder_16bit_unit #(
  parameter int CODE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [arenc_pkg::TOTAL_BITS-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [arenc_pkg::COUNT_BITS-1:0] cum_low,
  input  logic [arenc_pkg::TOTAL_BITS-1:0] cum_high,
  input  logic                            finish,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            lead_bit,
  output logic [arenc_pkg::PEND_BITS-1:0]  follow_count,
  output logic                            last
);
  import arenc_pkg::*;

  localparam int SPAN_BITS = CODE_BITS + 1;
  localparam int PROD_BITS = SPAN_BITS + TOTAL_BITS;
  localparam int ACC_BITS  = REM_BITS + SPAN_BITS;
  localparam int CNT_BITS  = $clog2(SPAN_BITS + 1);
  localparam int N_BITS    = $clog2(MAX_RESULTS + 1);

  localparam logic [CODE_BITS-1:0] QTR_1  = CODE_BITS'(1) << (CODE_BITS - 2);
  localparam logic [CODE_BITS-1:0] HALF_V = CODE_BITS'(1) << (CODE_BITS - 1);
  localparam logic [CODE_BITS-1:0] QTR_3  = QTR_1 + HALF_V;

  // One restoring division step: the remainder sits above the dividend/quotient bits.
  function automatic logic [ACC_BITS-1:0] div_step(input logic [ACC_BITS-1:0] a,
                                                   input logic [TOTAL_BITS-1:0] d);
    logic [ACC_BITS-1:0] s;
    logic [REM_BITS-1:0] r;
    s = {a[ACC_BITS-2:0], 1'b0};
    r = s[ACC_BITS-1 -: REM_BITS];
    if (r >= {1'b0, d}) begin
      s[ACC_BITS-1 -: REM_BITS] = r - {1'b0, d};
      s[0] = 1'b1;
    end
    return s;
  endfunction

  pc_t                    pc;
  pc_t                    pc_next;
  uword_t                 uw;
  logic                   wait_step;
  logic                   cond_hit;

  logic [TOTAL_BITS-1:0]  total_count;
  logic [CODE_BITS-1:0]   range_low;
  logic [CODE_BITS-1:0]   range_high;
  logic [PEND_BITS-1:0]   pending_bits;
  logic [COUNT_BITS-1:0]  cl_reg;
  logic [TOTAL_BITS-1:0]  ch_reg;
  logic [ACC_BITS-1:0]    acc_hi;
  logic [ACC_BITS-1:0]    acc_lo;
  logic [CNT_BITS-1:0]    cnt;
  logic [N_BITS-1:0]      n_res;
  logic                   hold_valid;
  logic                   hold_bit;
  logic [PEND_BITS-1:0]   hold_follow;

  logic [SPAN_BITS-1:0]   span;
  logic [TOTAL_BITS-1:0]  mul_arg;
  logic [PROD_BITS-1:0]   prod;
  logic [SPAN_BITS-1:0]   hi_sum;
  logic [SPAN_BITS-1:0]   lo_sum;
  logic                   item_bad;
  logic                   is_e1;
  logic                   is_e2;
  logic                   is_e3;
  logic                   renorm_go;
  logic                   emit_keep;
  logic                   push_req;
  logic                   push;
  logic                   out_free;
  logic [PEND_BITS-1:0]   pend_inc;

  assign uw       = ucode_rom(pc);
  assign in_stall = (pc != PC_IDLE);

  assign span    = {1'b0, range_high} - {1'b0, range_low} + SPAN_BITS'(1);
  assign mul_arg = (uw.op == OP_MUL_HI) ? ch_reg : {1'b0, cl_reg};
  assign prod    = PROD_BITS'(span) * PROD_BITS'(mul_arg);
  assign hi_sum  = SPAN_BITS'(range_low) + acc_hi[SPAN_BITS-1:0] - SPAN_BITS'(1);
  assign lo_sum  = SPAN_BITS'(range_low) + acc_lo[SPAN_BITS-1:0];

  assign item_bad = (total_count == '0) || (total_count > TOTAL_MAX) ||
                    (cum_high > total_count) || ({1'b0, cum_low} >= cum_high);

  assign is_e1     = (range_high < HALF_V);
  assign is_e2     = !is_e1 && (range_low >= HALF_V);
  assign is_e3     = !is_e1 && !is_e2 && (range_low >= QTR_1) && (range_high < QTR_3);
  assign renorm_go = is_e1 || is_e2 || is_e3;
  assign pend_inc  = (pending_bits == '1) ? pending_bits : pending_bits + PEND_BITS'(1);

  // Results beyond the per-item limit are dropped without touching the hold stage.
  assign emit_keep = (uw.op == OP_RENORM) && (is_e1 || is_e2) &&
                     (n_res < N_BITS'(MAX_RESULTS));
  assign out_free  = !out_valid || !out_stall;
  assign push_req  = hold_valid && (emit_keep || (uw.op == OP_FLUSH));
  assign push      = push_req && out_free;

  always_comb begin
    case (uw.op)
      OP_IDLE:   wait_step = !in_valid || (!finish && item_bad);
      OP_RENORM: wait_step = push_req && !out_free;
      OP_FLUSH:  wait_step = push_req && !out_free;
      default:   wait_step = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.cond)
      COND_NONE:     cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_FIN:      cond_hit = finish;
      COND_DIV_MORE: cond_hit = (cnt != CNT_BITS'(1));
      COND_RENORM:   cond_hit = renorm_go;
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (wait_step) begin
      pc_next = pc;
    end else if (cond_hit) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + PC_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= PC_IDLE;
      total_count  <= TOTAL_BITS'(1);
      range_low    <= '0;
      range_high   <= '1;
      pending_bits <= '0;
      cnt          <= '0;
      n_res        <= '0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_write) begin
        total_count <= cfg_data;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (!wait_step) begin
        case (uw.op)
          OP_IDLE: begin
            n_res      <= '0;
            hold_valid <= 1'b0;
          end
          OP_MUL_LO: cnt <= CNT_BITS'(SPAN_BITS);
          OP_DIV:    cnt <= cnt - CNT_BITS'(1);
          OP_NARROW: begin
            range_high <= hi_sum[CODE_BITS-1:0];
            range_low  <= lo_sum[CODE_BITS-1:0];
          end
          OP_RENORM: begin
            if (is_e1) begin
              pending_bits <= '0;
              range_low    <= range_low << 1;
              range_high   <= (range_high << 1) | CODE_BITS'(1);
            end else if (is_e2) begin
              pending_bits <= '0;
              range_low    <= (range_low - HALF_V) << 1;
              range_high   <= ((range_high - HALF_V) << 1) | CODE_BITS'(1);
            end else if (is_e3) begin
              pending_bits <= pend_inc;
              range_low    <= (range_low - QTR_1) << 1;
              range_high   <= ((range_high - QTR_1) << 1) | CODE_BITS'(1);
            end
            if (emit_keep) begin
              hold_valid <= 1'b1;
              n_res      <= n_res + N_BITS'(1);
            end
          end
          OP_FLUSH: hold_valid <= 1'b0;
          OP_FIN: begin
            pending_bits <= '0;
            range_low    <= '0;
            range_high   <= '1;
            hold_valid   <= 1'b1;
            n_res        <= N_BITS'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      lead_bit     <= hold_bit;
      follow_count <= hold_follow;
      last         <= (uw.op == OP_FLUSH);
    end
    if (!wait_step) begin
      case (uw.op)
        OP_IDLE: begin
          cl_reg <= cum_low;
          ch_reg <= cum_high;
        end
        OP_MUL_HI: acc_hi <= ACC_BITS'(prod);
        OP_MUL_LO: acc_lo <= ACC_BITS'(prod);
        OP_DIV: begin
          acc_hi <= div_step(acc_hi, total_count);
          acc_lo <= div_step(acc_lo, total_count);
        end
        OP_RENORM: begin
          if (emit_keep) begin
            hold_bit    <= is_e2;
            hold_follow <= pending_bits;
          end
        end
        OP_FIN: begin
          hold_bit    <= (range_low >= QTR_1);
          hold_follow <= pend_inc;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_finish_jumps: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && finish) |=> (pc == PC_FIN))
    else $error("finish beat did not enter the termination step");

  a_fin_resets: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_FIN) |=> (range_low == '0) && (pending_bits == '0) && hold_valid &&
                       (pc == PC_FLUSH))
    else $error("termination did not reset the coder state");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_FLUSH && !wait_step) |=> (!hold_valid && pc == PC_IDLE))
    else $error("hold stage not emptied at the end of an item");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_NARROW) |-> (acc_hi[SPAN_BITS-1:0] <= span) && (acc_lo[SPAN_BITS-1:0] <= span))
    else $error("divider quotient exceeds the range span");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    n_res <= N_BITS'(MAX_RESULTS))
    else $error("result count beyond the per-item limit");
`endif

endmodule
